// File: rtl/fdc_pkg.sv
// Shared types and constants for the floppy DMA controller with byte FIFO.
`default_nettype none
package fdc_pkg;

    localparam int FIFO_BYTES = 6;
    localparam int FIFO_W     = 8 * FIFO_BYTES;
    localparam int FILL_W     = $clog2(FIFO_BYTES + 1);

    localparam logic [15:0] SYNC_WORD_RESET = 16'h4489;
    localparam logic [31:0] BYTE_VALID_AGE  = 32'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_WORD   = 2'd0;
    localparam logic [1:0] CFG_SYNC_ENABLE = 2'd1;

    typedef enum logic [1:0] {
        REQ_LENGTH = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_SLOT   = 2'd2,
        REQ_STATUS = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_WAIT  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_WRITE = 2'd3
    } dma_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] length_value;
        logic [7:0]  head_byte;
        logic [15:0] mem_word;
        logic        drive_selected;
        logic        dma_enabled;
        logic [31:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic        irq_block_done;
        logic        irq_sync;
        logic        disk_write_valid;
        logic [7:0]  disk_write_byte;
        logic        mem_word_taken;
        logic        mem_write_valid;
        logic [15:0] mem_write_word;
        logic [15:0] status_data;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic flush;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic flush_start;
        logic flush_more;
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/floppy_dma_controller_fifo.sv
// Top level: floppy DMA controller with byte FIFO, stream and config ports.
// Usage:
//   s_* carries requests: s_tuser is the request kind (length write, disk
//   byte tick, DMA word slot, status read), s_tdata the operands.
//   m_* carries result items; m_tlast marks the final result of a request.
//   cfg_* writes sync_word (index 0) and word_sync_enable (index 1); other
//   indexes are ignored. cfg_ready is always high; write only while idle.
// Timing:
//   A request is taken in ST_IDLE and evaluated in ST_EXEC once the output
//   register is free; its result is on m_* the cycle after evaluation.
//   A write slot that ends a block drains the FIFO, one result per byte,
//   oldest first: the slot's own result gives the first byte, then ST_FLUSH
//   gives each byte left once the output register frees (2 to 6 bytes in all).
//   A new request is taken only in ST_IDLE, not during evaluation or flush;
//   the next request is taken while the result still waits.
// Stall: a result waits in the output register until m_tready; evaluating
//   the next request stalls until that register frees.
// Reset (aresetn low, synchronous): DMA off, FIFO empty, length 0, sync
//   word 0x4489, word sync off, no result pending.
`default_nettype none
module floppy_dma_controller_fifo
    import fdc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] length_value, [23:16] head_byte, [39:24] mem_word,
    // [40] drive_selected, [41] dma_enabled, [73:42] time_now, [79:74] zero
    input  wire logic [79:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] status_data, [31:16] mem_write_word, [32] mem_write_valid,
    // [33] mem_word_taken, [41:34] disk_write_byte, [42] disk_write_valid,
    // [43] irq_sync, [44] irq_block_done, [47:45] zero
    output logic [47:0]      m_tdata,
    output logic             m_tlast,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] sync_word_reg;
    logic        sync_enable_reg;
    in_item_t    in_item;
    dp_cmd_t     cmd;
    dp_status_t  status;
    result_t     out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg   <= SYNC_WORD_RESET;
            sync_enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SYNC_WORD:   sync_word_reg   <= cfg_data;
                CFG_SYNC_ENABLE: sync_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // unpack the request
    assign in_item.req_type       = req_type_t'(s_tuser);
    assign in_item.length_value   = s_tdata[15:0];
    assign in_item.head_byte      = s_tdata[23:16];
    assign in_item.mem_word       = s_tdata[39:24];
    assign in_item.drive_selected = s_tdata[40];
    assign in_item.dma_enabled    = s_tdata[41];
    assign in_item.time_now       = s_tdata[73:42];

    fdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fdc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_item     (in_item),
        .sync_word   (sync_word_reg),
        .sync_enable (sync_enable_reg),
        .out_ready   (m_tready),
        .status      (status),
        .out_data    (out_data),
        .out_valid   (m_tvalid),
        .out_last    (m_tlast)
    );

    // pack the result
    assign m_tdata = {3'b000, out_data};

endmodule
`default_nettype wire

// File: rtl/fdc_ctrl.sv
// Request sequencer: accept, execute, then optional flush of write bytes.
`default_nettype none
module fdc_ctrl
    import fdc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    state_next = status.flush_start ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (status.out_free && !status.flush_more) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:  cmd.exec  = status.out_free;
            ST_FLUSH: cmd.flush = status.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/fdc_datapath.sv
// DMA state, byte FIFO, request evaluation and the result register.
`default_nettype none
module fdc_datapath
    import fdc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire in_item_t    in_item,
    input  wire logic [15:0] sync_word,
    input  wire logic        sync_enable,
    input  wire logic        out_ready,
    output dp_status_t       status,
    output result_t          out_data,
    output logic             out_valid,
    output logic             out_last
);

    // byte at position fill-1, i.e. the oldest byte in the FIFO
    function automatic logic [7:0] oldest_byte(logic [FIFO_W-1:0] f, logic [FILL_W-1:0] n);
        logic [FIFO_W-1:0] sh;
        sh = f >> {n - FILL_W'(1), 3'b000};
        return sh[7:0];
    endfunction

    in_item_t          item_reg;
    dma_mode_t         mode_reg, mode_next;
    logic [15:0]       length_reg, length_next;
    logic [FIFO_W-1:0] fifo_reg, fifo_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              weq_reg, weq_next;
    logic [7:0]        last_byte_reg, last_byte_next;
    logic [31:0]       last_time_reg, last_time_next;
    result_t           out_data_reg, res;
    logic              out_valid_reg, out_last_reg;

    logic [FILL_W-1:0] fill_base;
    logic [FIFO_W-1:0] fifo_tmp;
    logic [FIFO_W-1:0] word_sh;
    logic [15:0]       length_dec;
    logic [31:0]       age;
    logic              flush_start;

    always_comb begin
        mode_next      = mode_reg;
        length_next    = length_reg;
        fifo_next      = fifo_reg;
        fill_next      = fill_reg;
        weq_next       = weq_reg;
        last_byte_next = last_byte_reg;
        last_time_next = last_time_reg;
        res            = '0;
        flush_start    = 1'b0;
        fill_base      = fill_reg;
        fifo_tmp       = fifo_reg;
        word_sh        = fifo_reg >> {fill_reg - FILL_W'(2), 3'b000};
        length_dec     = length_reg - 16'd1;
        age            = item_reg.time_now - last_time_reg;

        if (cmd.flush) begin
            res.disk_write_byte  = oldest_byte(fifo_reg, fill_reg);
            res.disk_write_valid = 1'b1;
            fill_next            = fill_reg - FILL_W'(1);
        end else begin
            case (item_reg.req_type)
                REQ_LENGTH: begin
                    length_next = item_reg.length_value;
                    if (!item_reg.length_value[15]) begin
                        mode_next = MODE_OFF;
                        fifo_next = '0;
                        fill_next = '0;
                    end else if (length_reg[15]) begin
                        if (length_reg[14] && item_reg.length_value[14]) begin
                            mode_next = MODE_WRITE;
                        end else if (sync_enable) begin
                            mode_next = MODE_WAIT;
                        end else begin
                            mode_next = MODE_READ;
                        end
                        fifo_next = '0;
                        fill_next = '0;
                    end
                end
                REQ_TICK: begin
                    if (item_reg.drive_selected) begin
                        if (mode_reg inside {MODE_WAIT, MODE_READ}) begin
                            last_byte_next = item_reg.head_byte;
                            last_time_next = item_reg.time_now;
                            // full FIFO drops its oldest word first
                            if (fill_reg >= FILL_W'(FIFO_BYTES)) begin
                                fill_base = FILL_W'(FIFO_BYTES - 2);
                            end
                            fifo_tmp  = {fifo_reg[FIFO_W-9:0], item_reg.head_byte};
                            fifo_next = fifo_tmp;
                            fill_next = fill_base + FILL_W'(1);
                            weq_next  = (fill_next >= FILL_W'(2)) &&
                                        (fifo_tmp[15:0] == sync_word);
                            res.irq_sync = weq_next;
                            if (weq_next && mode_reg == MODE_WAIT) begin
                                mode_next = MODE_READ;
                                fifo_next = '0;
                                fill_next = '0;
                            end
                        end else if (mode_reg == MODE_WRITE && fill_reg != '0) begin
                            res.disk_write_byte  = oldest_byte(fifo_reg, fill_reg);
                            res.disk_write_valid = 1'b1;
                            fill_next            = fill_reg - FILL_W'(1);
                        end
                    end
                end
                REQ_SLOT: begin
                    if (item_reg.drive_selected && length_reg[13:0] != '0) begin
                        if (mode_reg == MODE_READ && fill_reg >= FILL_W'(2)) begin
                            res.mem_write_word  = word_sh[15:0];
                            res.mem_write_valid = 1'b1;
                            fill_next           = fill_reg - FILL_W'(2);
                            length_next         = length_dec;
                            if (length_dec[13:0] == '0) begin
                                res.irq_block_done = 1'b1;
                                mode_next          = MODE_OFF;
                            end
                        end else if (mode_reg == MODE_WRITE &&
                                     fill_reg <= FILL_W'(FIFO_BYTES - 2)) begin
                            fifo_tmp           = {fifo_reg[FIFO_W-17:0], item_reg.mem_word};
                            fifo_next          = fifo_tmp;
                            fill_next          = fill_reg + FILL_W'(2);
                            res.mem_word_taken = 1'b1;
                            length_next        = length_dec;
                            if (length_dec[13:0] == '0) begin
                                // end of block: start draining, oldest byte first
                                res.irq_block_done   = 1'b1;
                                mode_next            = MODE_OFF;
                                flush_start          = 1'b1;
                                res.disk_write_byte  = oldest_byte(fifo_tmp,
                                                           fill_reg + FILL_W'(2));
                                res.disk_write_valid = 1'b1;
                                fill_next            = fill_reg + FILL_W'(1);
                            end
                        end
                    end
                end
                REQ_STATUS: begin
                    res.status_data[7:0] = last_byte_reg;
                    res.status_data[15]  = age <= BYTE_VALID_AGE;
                    res.status_data[14]  = item_reg.dma_enabled && mode_reg != MODE_OFF;
                    res.status_data[13]  = length_reg[14];
                    res.status_data[12]  = weq_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
        end
        if (cmd.exec || cmd.flush) begin
            out_data_reg <= res;
            out_last_reg <= cmd.flush ? (fill_reg <= FILL_W'(1)) : !flush_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_OFF;
            length_reg    <= '0;
            fifo_reg      <= '0;
            fill_reg      <= '0;
            weq_reg       <= 1'b0;
            last_byte_reg <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec || cmd.flush) begin
                mode_reg      <= mode_next;
                length_reg    <= length_next;
                fifo_reg      <= fifo_next;
                fill_reg      <= fill_next;
                weq_reg       <= weq_next;
                last_byte_reg <= last_byte_next;
                last_time_reg <= last_time_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.flush_start = flush_start;
    assign status.flush_more  = fill_reg > FILL_W'(1);

    assign out_data  = out_data_reg;
    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

// File: tb/sv/fdc_dma_predictor_pkg.sv
// Result predictor and scoreboard for the floppy DMA controller testbench.
package fdc_dma_predictor_pkg;
    import fdc_pkg::*;

    typedef struct packed {
        result_t res;
        logic    last_flag;
    } expected_t;

    class fdc_dma_predictor;
        // configuration copy
        logic [15:0]       sync_word;
        logic              sync_enable;
        // controller state copy
        dma_mode_t         mode;
        logic [15:0]       length;
        logic [FIFO_W-1:0] fifo;
        int unsigned       fill;
        logic              word_equal;
        logic [7:0]        last_byte;
        logic [31:0]       last_time;

        expected_t   expected_results[$];
        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_sync;
        int unsigned n_done;
        int unsigned n_flush;

        function new();
            sync_word   = SYNC_WORD_RESET;
            sync_enable = 1'b0;
            mode        = MODE_OFF;
            length      = '0;
            fifo        = '0;
            fill        = 0;
            word_equal  = 1'b0;
            last_byte   = '0;
            last_time   = '0;
            errors      = 0;
            n_checked   = 0;
            n_sync      = 0;
            n_done      = 0;
            n_flush     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] val);
            if (idx == CFG_SYNC_WORD)
                sync_word = val;
            else if (idx == CFG_SYNC_ENABLE)
                sync_enable = val[0];
        endfunction

        function void fifo_clear();
            fifo = '0;
            fill = 0;
        endfunction

        // full FIFO drops its oldest word before the push
        function void fifo_push(logic [7:0] b);
            if (fill >= FIFO_BYTES)
                fill = FIFO_BYTES - 2;
            fifo = {fifo[FIFO_W-9:0], b};
            fill++;
        endfunction

        function logic [7:0] fifo_pop();
            if (fill == 0)
                return 8'h00;
            fill--;
            return fifo[8*fill +: 8];
        endfunction

        function logic [15:0] fifo_pop_word();
            if (fill < 2)
                return 16'h0000;
            fill -= 2;
            return fifo[8*fill +: 16];
        endfunction

        function void expect_result(result_t res, logic last_flag);
            expected_t e;
            e.res       = res;
            e.last_flag = last_flag;
            expected_results.push_back(e);
        endfunction

        function void log_request(in_item_t r);
            result_t     res;
            logic [15:0] prev;
            logic [15:0] st;
            logic [31:0] age;
            res = '0;
            case (r.req_type)
                REQ_LENGTH: begin
                    prev   = length;
                    length = r.length_value;
                    if (!r.length_value[15]) begin
                        mode = MODE_OFF;
                        fifo_clear();
                    end else if (prev[15]) begin
                        if (prev[14] && r.length_value[14])
                            mode = MODE_WRITE;
                        else if (sync_enable)
                            mode = MODE_WAIT;
                        else
                            mode = MODE_READ;
                        fifo_clear();
                    end
                end
                REQ_TICK: begin
                    if (r.drive_selected) begin
                        if (mode == MODE_WAIT || mode == MODE_READ) begin
                            last_byte = r.head_byte;
                            last_time = r.time_now;
                            fifo_push(r.head_byte);
                            word_equal = (fill >= 2) && (fifo[15:0] == sync_word);
                            if (word_equal) begin
                                res.irq_sync = 1'b1;
                                n_sync++;
                                if (mode == MODE_WAIT) begin
                                    mode = MODE_READ;
                                    fifo_clear();
                                end
                            end
                        end else if (mode == MODE_WRITE && fill > 0) begin
                            res.disk_write_byte  = fifo_pop();
                            res.disk_write_valid = 1'b1;
                        end
                    end
                end
                REQ_SLOT: begin
                    if (r.drive_selected && length[13:0] != 14'd0) begin
                        if (mode == MODE_READ && fill >= 2) begin
                            res.mem_write_word  = fifo_pop_word();
                            res.mem_write_valid = 1'b1;
                            length = length - 16'd1;
                            if (length[13:0] == 14'd0) begin
                                res.irq_block_done = 1'b1;
                                mode = MODE_OFF;
                                n_done++;
                            end
                        end else if (mode == MODE_WRITE && fill + 2 <= FIFO_BYTES) begin
                            fifo_push(r.mem_word[15:8]);
                            fifo_push(r.mem_word[7:0]);
                            res.mem_word_taken = 1'b1;
                            length = length - 16'd1;
                            if (length[13:0] == 14'd0) begin
                                // block end: drain every byte left, oldest first
                                res.irq_block_done   = 1'b1;
                                res.disk_write_byte  = fifo_pop();
                                res.disk_write_valid = 1'b1;
                                if (fill > 0)
                                    n_flush++;
                                while (fill > 0) begin
                                    expect_result(res, 1'b0);
                                    res = '0;
                                    res.disk_write_byte  = fifo_pop();
                                    res.disk_write_valid = 1'b1;
                                end
                                mode = MODE_OFF;
                                n_done++;
                            end
                        end
                    end
                end
                default: begin
                    st  = {8'h00, last_byte};
                    age = r.time_now - last_time;
                    if (age <= BYTE_VALID_AGE)
                        st[15] = 1'b1;
                    if (r.dma_enabled && mode != MODE_OFF)
                        st[14] = 1'b1;
                    if (length[14])
                        st[13] = 1'b1;
                    if (word_equal)
                        st[12] = 1'b1;
                    res.status_data = st;
                end
            endcase
            expect_result(res, 1'b1);
        endfunction

        function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (exp_val !== act_val) begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void compare_result(logic [47:0] data, logic last_flag);
            expected_t e;
            result_t   got;
            if (expected_results.size() == 0) begin
                $error("unexpected result: tdata %h tlast %b", data, last_flag);
                errors++;
                return;
            end
            e   = expected_results.pop_front();
            got = result_t'(data[44:0]);
            n_checked++;
            check_field("status_data", 32'(e.res.status_data), 32'(got.status_data));
            check_field("mem_write_word", 32'(e.res.mem_write_word),
                        32'(got.mem_write_word));
            check_field("mem_write_valid", 32'(e.res.mem_write_valid),
                        32'(got.mem_write_valid));
            check_field("mem_word_taken", 32'(e.res.mem_word_taken),
                        32'(got.mem_word_taken));
            check_field("disk_write_byte", 32'(e.res.disk_write_byte),
                        32'(got.disk_write_byte));
            check_field("disk_write_valid", 32'(e.res.disk_write_valid),
                        32'(got.disk_write_valid));
            check_field("irq_sync", 32'(e.res.irq_sync), 32'(got.irq_sync));
            check_field("irq_block_done", 32'(e.res.irq_block_done),
                        32'(got.irq_block_done));
            check_field("tlast", 32'(e.last_flag), 32'(last_flag));
            check_field("tdata pad", 32'd0, 32'(data[47:45]));
        endfunction
    endclass

endpackage

// File: tb/sv/floppy_dma_controller_fifo_tb.sv
// Self-checking testbench for the floppy DMA controller with byte FIFO.
module floppy_dma_controller_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fdc_pkg::*;
    import fdc_dma_predictor_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on any channel
    localparam int RANDOM_TARGET  = 500;   // random requests after the directed part
    localparam int END_WAIT       = 12;    // wait after the drain for a stray result to show up

    // register indexes the block does not implement
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    fdc_dma_predictor predictor;

    // idle percentages per side
    int          sender_idle;
    int          recv_idle;
    int          quiet = 0;

    logic [31:0] now_stamp;     // time stamp carried by each request
    bit          time_jumps;
    int          n_requests;
    int          n_directed;

    floppy_dma_controller_fifo u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: check every accepted result, then decide tready for the
    // next edge.
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            predictor.compare_result(m_tdata, m_tlast);
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog: a correct block never leaves every channel silent this long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic pick_drive();
        return $urandom_range(0, 9) != 0;
    endfunction

    // Drive one request and hold it until accepted. tvalid stays high on
    // return so back-to-back requests never lower and raise it in one step.
    task automatic issue(input req_type_t kind, input logic [15:0] len, input logic [7:0] hb,
                         input logic [15:0] mw, input logic drv, input logic en);
        in_item_t r;
        r.req_type       = kind;
        r.length_value   = len;
        r.head_byte      = hb;
        r.mem_word       = mw;
        r.drive_selected = drv;
        r.dma_enabled    = en;
        r.time_now       = now_stamp;
        while ($urandom_range(0, 99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req_type;
        s_tdata  <= {6'b0, r.time_now, r.dma_enabled, r.drive_selected,
                     r.mem_word, r.head_byte, r.length_value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predictor.log_request(r);
        n_requests++;
        if (time_jumps && $urandom_range(0, 99) < 5)
            now_stamp = $urandom;
        else
            now_stamp += $urandom_range(0, 4);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        predictor.set_register(idx, val);
    endtask

    // Registers change only with the block idle: every expected result in.
    task automatic reconfigure(input logic [15:0] sync_val, input logic en, input bit spare);
        s_tvalid <= 1'b0;
        while (predictor.expected_results.size() != 0) @(posedge aclk);
        write_register(CFG_SYNC_WORD, sync_val);
        write_register(CFG_SYNC_ENABLE, {15'($urandom), en});
        if (spare) begin
            write_register(CFG_SPARE_LO, 16'($urandom));
            write_register(CFG_SPARE_HI, 16'hFFFF);
        end
        cfg_valid <= 1'b0;
    endtask

    // One random transfer: mostly a proper enable pair followed by ticks,
    // slots and status reads that fit the mode, sometimes plain noise.
    task automatic run_session();
        int          pick;
        int          n_ops;
        int          op;
        logic [13:0] cnt;
        logic [15:0] first_len;
        logic [15:0] second_len;
        logic [7:0]  hb;
        logic        b14;
        pick = $urandom_range(0, 99);
        op   = $urandom_range(0, 99);
        if (op < 5)
            cnt = 14'd0;
        else if (op < 12)
            cnt = 14'($urandom);
        else
            cnt = 14'($urandom_range(1, 6));
        n_ops = $urandom_range(3, 20);

        // often stop first, so the enable pair starts from DMA off
        if ($urandom_range(0, 99) < 40)
            issue(REQ_LENGTH, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom),
                  16'($urandom), pick_drive(), 1'($urandom));

        if (pick < 40) begin
            // write transfer; now and then the first write lacks the write bit
            first_len  = {2'b11, cnt};
            second_len = {2'b11, cnt};
            if ($urandom_range(0, 99) < 15)
                first_len[14] = 1'b0;
            issue(REQ_LENGTH, first_len, 8'($urandom), 16'($urandom), pick_drive(), 1'($urandom));
            issue(REQ_LENGTH, second_len, 8'($urandom), 16'($urandom), pick_drive(), 1'($urandom));
            repeat (n_ops) begin
                op = $urandom_range(0, 99);
                if (op < 45)
                    issue(REQ_SLOT, 16'($urandom), 8'($urandom), 16'($urandom),
                          pick_drive(), 1'($urandom));
                else if (op < 85)
                    issue(REQ_TICK, 16'($urandom), 8'($urandom), 16'($urandom),
                          pick_drive(), 1'($urandom));
                else
                    issue(REQ_STATUS, 16'($urandom), 8'($urandom), 16'($urandom),
                          pick_drive(), 1'($urandom));
            end
        end else if (pick < 85) begin
            // read or wait-for-sync transfer: the write bit never set in both
            b14        = 1'($urandom);
            first_len  = {1'b1, b14, cnt};
            second_len = {1'b1, b14 ? 1'b0 : 1'($urandom), cnt};
            issue(REQ_LENGTH, first_len, 8'($urandom), 16'($urandom), pick_drive(), 1'($urandom));
            issue(REQ_LENGTH, second_len, 8'($urandom), 16'($urandom), pick_drive(), 1'($urandom));
            repeat (n_ops) begin
                op = $urandom_range(0, 99);
                if (op < 60) begin
                    if ($urandom_range(0, 99) < 15) begin
                        // sync mark in two consecutive ticks
                        issue(REQ_TICK, 16'($urandom), predictor.sync_word[15:8],
                              16'($urandom), 1'b1, 1'($urandom));
                        issue(REQ_TICK, 16'($urandom), predictor.sync_word[7:0],
                              16'($urandom), 1'b1, 1'($urandom));
                    end else begin
                        hb = 8'($urandom);
                        if ($urandom_range(0, 99) < 25)
                            hb = $urandom_range(0, 1) ? predictor.sync_word[15:8]
                                                      : predictor.sync_word[7:0];
                        issue(REQ_TICK, 16'($urandom), hb, 16'($urandom),
                              pick_drive(), 1'($urandom));
                    end
                end else if (op < 90) begin
                    issue(REQ_SLOT, 16'($urandom), 8'($urandom), 16'($urandom),
                          pick_drive(), 1'($urandom));
                end else begin
                    issue(REQ_STATUS, 16'($urandom), 8'($urandom), 16'($urandom),
                          pick_drive(), 1'($urandom));
                end
            end
        end else begin
            repeat ($urandom_range(2, 6))
                issue(req_type_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                      16'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int          ph;
        int          goal;
        int          errors;
        logic [15:0] sync_val;
        logic        en;

        predictor   = new();
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= REQ_LENGTH;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_SYNC_WORD;
        cfg_data   <= '0;
        sender_idle = 38;
        recv_idle   = 82;
        now_stamp   = '0;
        time_jumps  = 0;
        n_requests  = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed: write transfer with reset config ----
        // status right after reset: byte age 0, so byte-valid is set
        issue(REQ_STATUS, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        // single enabling write only stores the length
        issue(REQ_LENGTH, 16'hC004, 8'h00, 16'h0000, 1'b0, 1'b0);
        issue(REQ_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
        // second enabling write with the write bit in both: write mode
        issue(REQ_LENGTH, 16'hC004, 8'h00, 16'h0000, 1'b1, 1'b1);
        // write tick with an empty FIFO writes nothing
        issue(REQ_TICK, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0);
        // slot without a selected drive is ignored
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'hFFFF, 1'b0, 1'b1);
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'hFFFF, 1'b1, 1'b1);
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'hA55A, 1'b1, 1'b1);
        // FIFO full: no room for another word
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'h1234, 1'b1, 1'b1);
        issue(REQ_TICK, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        issue(REQ_TICK, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        // last word of the block: six-byte flush
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'h8001, 1'b1, 1'b1);
        issue(REQ_STATUS, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0);

        // ---- directed: wait for sync, then read; spare indexes ignored ----
        reconfigure(SYNC_WORD_RESET, 1'b1, 1'b1);
        now_stamp = 32'hFFFF_FFF0;
        // length still has bit 15 from the write block: this enables
        issue(REQ_LENGTH, 16'h8003, 8'h00, 16'h0000, 1'b1, 1'b1);
        // re-enable in the same mode clears the FIFO again
        issue(REQ_LENGTH, 16'h8003, 8'h00, 16'h0000, 1'b1, 1'b1);
        // slot in wait mode does nothing
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        issue(REQ_TICK, 16'h0000, SYNC_WORD_RESET[15:8], 16'h0000, 1'b1, 1'b1);
        issue(REQ_TICK, 16'h0000, SYNC_WORD_RESET[7:0], 16'h0000, 1'b1, 1'b1);
        // read slot with fewer than two bytes does nothing
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        issue(REQ_TICK, 16'h0000, 8'h12, 16'h0000, 1'b1, 1'b1);
        now_stamp = 32'hFFFF_FFFD;
        issue(REQ_TICK, 16'h0000, 8'h34, 16'h0000, 1'b1, 1'b1);
        // byte age across the 32-bit wrap: 6, still valid
        now_stamp = 32'h0000_0003;
        issue(REQ_STATUS, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        issue(REQ_SLOT, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        // stop, then a stale status read
        issue(REQ_LENGTH, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1);
        now_stamp = 32'h8000_0000;
        issue(REQ_STATUS, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
        n_directed = n_requests;

        // ---- random: six settings, idling pattern changes every two ----
        time_jumps = 1;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin sync_val = SYNC_WORD_RESET;  en = 1'b0; end
                1: begin sync_val = SYNC_WORD_RESET;  en = 1'b1; end
                2: begin sync_val = 16'h0000;         en = 1'b1; end
                3: begin sync_val = 16'hFFFF;         en = 1'b0; end
                4: begin sync_val = 16'($urandom);    en = 1'b1; end
                default: begin sync_val = 16'hFFFF;   en = 1'b1; end
            endcase
            reconfigure(sync_val, en, 1'b0);
            if (ph < 2) begin
                sender_idle = 38;
                recv_idle   = 82;
            end else if (ph < 4) begin
                sender_idle = 82;
                recv_idle   = 38;
            end else begin
                sender_idle = 0;
                recv_idle   = 0;
            end
            goal = RANDOM_TARGET * (ph + 1) / 6;
            while (n_requests - n_directed < goal)
                run_session();
        end

        // drain, then give a stray result time to show up
        s_tvalid <= 1'b0;
        while (predictor.expected_results.size() != 0) @(posedge aclk);
        repeat (END_WAIT) @(posedge aclk);

        errors = predictor.errors + predictor.expected_results.size();
        $display("Covered %0d requests (%0d directed), %0d results checked, six sync settings.",
                 n_requests, n_directed, predictor.n_checked);
        $display("Sync matches %0d, blocks completed %0d, multi-byte write flushes %0d.",
                 predictor.n_sync, predictor.n_done, predictor.n_flush);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
